// File: design/alr_pkg.sv
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types and constants of the line raster core: request codes,
// controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package alr_pkg;

    // default screen geometry
    localparam int DEF_SCREEN_WIDTH  = 640;
    localparam int DEF_SCREEN_HEIGHT = 480;

    // fixed field widths
    localparam int X_W       = 10;
    localparam int Y_W       = 9;
    localparam int ADDR_IN_W = 16;
    localparam int DATA_W    = 8;

    // request codes
    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_MOVE  = 2'd1,
        REQ_DRAW  = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    // controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_RD,
        ST_RD_WAIT,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear_step;
        logic setup;
        logic issue;
        logic read_capture;
        logic push;
    } alr_cmd_t;

    // datapath to controller
    typedef struct packed {
        req_t req_in;
        logic clr_last;
        logic span_live;
        logic run_last;
        logic out_free;
    } alr_status_t;

endpackage

// File: design/alr_ram.sv
// ----------------------------------------------------------------------------
// alr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module alr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: design/alr_ctrl.sv
// ----------------------------------------------------------------------------
// alr_ctrl
// Request sequencer of the line raster core: clearing pass, span walk,
// byte read and hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module alr_ctrl
    import alr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  alr_status_t status,
    output alr_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clear_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (status.req_in)
                        REQ_CLEAR: state_next = ST_CLEAR;
                        REQ_MOVE:  state_next = ST_FINISH;
                        REQ_DRAW:  state_next = ST_SETUP;
                        REQ_READ:  state_next = ST_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.span_live ? ST_RUN : ST_FINISH;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (status.run_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last read-modify-write lands this cycle
                state_next = ST_FINISH;
            end
            ST_RD:
            begin
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                cmd.read_capture = 1'b1;
                state_next       = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/alr_datapath.sv
// ----------------------------------------------------------------------------
// alr_datapath
// Pen, request capture, span address walker, read-modify-write pipeline
// into the frame store, clear counter and output word register.
// ----------------------------------------------------------------------------
module alr_datapath
    import alr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  alr_cmd_t             cmd,
    output alr_status_t          status,
    input  logic [1:0]           req_type,
    input  logic [X_W-1:0]       target_x,
    input  logic [Y_W-1:0]       target_y,
    input  logic [ADDR_IN_W-1:0] read_address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_W-1:0]    read_data,
    output logic                 line_drawn
);

    localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int BYTE_W      = X_W - 3;

    // captured request and pen
    logic [X_W-1:0]       tx_reg;
    logic [Y_W-1:0]       ty_reg;
    logic [ADDR_IN_W-1:0] rd_addr_reg;
    logic [X_W-1:0]       pen_col_reg;
    logic [Y_W-1:0]       pen_row_reg;

    // span walker
    logic                 vert_reg;
    logic                 first_reg;
    logic [X_W-1:0]       cur_reg;
    logic [X_W-1:0]       end_reg;
    logic [2:0]           lo_bit_reg;
    logic [2:0]           hi_bit_reg;
    logic [2:0]           col_bit_reg;
    logic [AW-1:0]        run_addr_reg;

    // write pipeline
    logic                 wr_valid_reg;
    logic [AW-1:0]        wr_addr_reg;
    logic [DATA_W-1:0]    wr_mask_reg;

    // clear counter
    logic [AW-1:0]        clr_cnt_reg;

    // result and output word
    logic [DATA_W-1:0]    res_data_reg;
    logic                 res_drawn_reg;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    read_data_reg;
    logic                 line_drawn_reg;

    // setup decode
    logic                 is_vert;
    logic                 is_horz;
    logic [Y_W-1:0]       v_lo;
    logic [Y_W-1:0]       v_hi;
    logic [Y_W-1:0]       v_hi_c;
    logic [X_W-1:0]       h_lo;
    logic [X_W-1:0]       h_hi;
    logic [X_W-1:0]       h_hi_c;
    logic                 v_live;
    logic                 h_live;
    logic [Y_W-1:0]       row_sel;
    logic [BYTE_W-1:0]    byte_sel;
    logic [AW-1:0]        start_addr;

    // run datapath
    logic [2:0]           s_bit;
    logic [2:0]           e_bit;
    logic [DATA_W-1:0]    mask_now;
    logic [DATA_W-1:0]    ram_rdata;
    logic [AW-1:0]        ram_raddr;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [DATA_W-1:0]    ram_wdata;
    logic                 rd_in_range;

    // span decode from pen and target
    always_comb
    begin
        is_vert  = (tx_reg == pen_col_reg);
        is_horz  = !is_vert && (ty_reg == pen_row_reg);
        v_lo     = (ty_reg < pen_row_reg) ? ty_reg : pen_row_reg;
        v_hi     = (ty_reg < pen_row_reg) ? pen_row_reg : ty_reg;
        h_lo     = (tx_reg < pen_col_reg) ? tx_reg : pen_col_reg;
        h_hi     = (tx_reg < pen_col_reg) ? pen_col_reg : tx_reg;
        v_hi_c   = (32'(v_hi) >= SCREEN_HEIGHT) ? Y_W'(SCREEN_HEIGHT - 1) : v_hi;
        h_hi_c   = (32'(h_hi) >= SCREEN_WIDTH) ? X_W'(SCREEN_WIDTH - 1) : h_hi;
        v_live   = is_vert && (32'(tx_reg) < SCREEN_WIDTH) && (32'(v_lo) < SCREEN_HEIGHT);
        h_live   = is_horz && (32'(ty_reg) < SCREEN_HEIGHT) && (32'(h_lo) < SCREEN_WIDTH);
        row_sel  = is_vert ? v_lo : ty_reg;
        byte_sel = is_vert ? tx_reg[X_W-1:3] : h_lo[X_W-1:3];
        start_addr = AW'(32'(row_sel) * ROW_BYTES + 32'(byte_sel));
    end

    // byte mask for the current step, msb is the leftmost pixel
    always_comb
    begin
        s_bit = first_reg ? lo_bit_reg : 3'd0;
        e_bit = (cur_reg == end_reg) ? hi_bit_reg : 3'd7;
        if (vert_reg)
        begin
            mask_now = 8'h80 >> col_bit_reg;
        end
        else
        begin
            mask_now = (8'hFF >> s_bit) & (8'hFF << (3'd7 - e_bit));
        end
    end

    assign rd_in_range = (32'(rd_addr_reg) < STORE_BYTES);

    // request capture, pen and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_col_reg <= '0;
            pen_row_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (req_t'(req_type) == REQ_MOVE)
            begin
                pen_col_reg <= target_x;
                pen_row_reg <= target_y;
            end
            else if (req_t'(req_type) == REQ_CLEAR)
            begin
                pen_col_reg <= '0;
                pen_row_reg <= '0;
            end
        end
        else if (cmd.setup)
        begin
            if (is_vert)
            begin
                pen_row_reg <= ty_reg;
            end
            else if (is_horz)
            begin
                pen_col_reg <= tx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tx_reg        <= target_x;
            ty_reg        <= target_y;
            rd_addr_reg   <= read_address;
            res_data_reg  <= '0;
            res_drawn_reg <= 1'b0;
        end
        if (cmd.setup)
        begin
            res_drawn_reg <= is_vert || is_horz;
        end
        if (cmd.read_capture)
        begin
            res_data_reg <= rd_in_range ? ram_rdata : '0;
        end
    end

    // span walker: one byte per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            vert_reg     <= is_vert;
            first_reg    <= 1'b1;
            cur_reg      <= is_vert ? X_W'(v_lo) : X_W'(h_lo[X_W-1:3]);
            end_reg      <= is_vert ? X_W'(v_hi_c) : X_W'(h_hi_c[X_W-1:3]);
            lo_bit_reg   <= h_lo[2:0];
            hi_bit_reg   <= h_hi_c[2:0];
            col_bit_reg  <= tx_reg[2:0];
            run_addr_reg <= start_addr;
        end
        else if (cmd.issue)
        begin
            first_reg    <= 1'b0;
            cur_reg      <= cur_reg + X_W'(1);
            run_addr_reg <= run_addr_reg + (vert_reg ? AW'(ROW_BYTES) : AW'(1));
        end
        if (cmd.issue)
        begin
            wr_addr_reg <= run_addr_reg;
            wr_mask_reg <= mask_now;
        end
    end

    // write pipeline valid and clear counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg <= 1'b0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            wr_valid_reg <= cmd.issue;
            if (cmd.load)
            begin
                clr_cnt_reg <= '0;
            end
            else if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // frame store ports
    assign ram_raddr = cmd.issue ? run_addr_reg : rd_addr_reg[AW-1:0];
    assign ram_we    = cmd.clear_step || wr_valid_reg;
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : wr_addr_reg;
    assign ram_wdata = cmd.clear_step ? '0 : (ram_rdata | wr_mask_reg);

    alr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_BYTES)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            read_data_reg  <= res_data_reg;
            line_drawn_reg <= res_drawn_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign line_drawn = line_drawn_reg;

    // status to the controller
    assign status.req_in    = req_t'(req_type);
    assign status.clr_last  = (clr_cnt_reg == AW'(STORE_BYTES - 1));
    assign status.span_live = v_live || h_live;
    assign status.run_last  = (cur_reg == end_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    // clearing and span writes never share the write port
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear_step && wr_valid_reg))
        else $error("clear sweep collides with span write");

    // read-modify-write never reads the byte being written
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && wr_valid_reg) |-> (ram_raddr != wr_addr_reg))
        else $error("span read hits pending write");

    // walker stays inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (32'(run_addr_reg) < STORE_BYTES))
        else $error("span address beyond frame store");

    // a new word is loaded only when the previous one is gone
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.push)
        else $error("output word overwritten");

endmodule

// File: design/axis_line_raster_1bpp_core.sv
// ----------------------------------------------------------------------------
// axis_line_raster_1bpp_core
// Monochrome framebuffer with clear, move, axis aligned draw-to and byte read.
// ----------------------------------------------------------------------------
// One request in, one word out. The frame store is a single RAM with one write
// and one read port, and every pixel update is a read-modify-write of one
// byte per cycle, so that port sets the timing. A vertical span updates one
// byte per on-screen row and a horizontal span each touched byte once. Clear
// walks the whole store, ROW_BYTES * SCREEN_HEIGHT bytes (38400 at 640x480),
// at one byte per cycle, and after reset the same clearing pass runs with
// in_ready low. The output word sits in its own register, so a result waiting
// for out_ready does not hold the next request from being accepted.
// ----------------------------------------------------------------------------
module axis_line_raster_1bpp_core
    import alr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [X_W-1:0]       target_x,
    input  logic [Y_W-1:0]       target_y,
    input  logic [ADDR_IN_W-1:0] read_address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_W-1:0]    read_data,
    output logic                 line_drawn
);

    alr_cmd_t    cmd;
    alr_status_t status;

    // sequencer
    alr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // pen, walker and frame store
    alr_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_type     (req_type),
        .target_x     (target_x),
        .target_y     (target_y),
        .read_address (read_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .line_drawn   (line_drawn)
    );

endmodule
